// ===== sv/zmtc_pkg.sv =====
// shared types and constants for the zero-momentum time correlator
package zmtc_pkg;

  localparam int TIDX_W    = 8;   // time slice coordinate
  localparam int FIELD_W   = 16;  // signed Q8.8 sample
  localparam int TE_W      = 9;   // time_extent register
  localparam int NORM_W    = 32;  // Q0.32 reciprocal norm
  localparam int CFG_W     = 32;  // config write data
  localparam int CFG_IDX_W = 1;
  localparam int SUM_W     = 40;  // per-slice running sum, wraps
  localparam int OPND_W    = 32;  // clamped multiplier operand
  localparam int ACC_W     = 64;  // saturating lag accumulator
  localparam int LAG_W     = 6;
  localparam int LAGS_W    = 7;   // holds the lag count itself
  localparam int LAG_LIMIT = 64;
  localparam int CORR_W    = 32;  // Q16.16 result
  localparam int MIN_TIME  = 4;
  localparam int TE_RESET  = 64;
  localparam int INV_RESET = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_TIME_EXTENT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_NORM    = 1'b1;

  typedef struct packed {
    logic [TIDX_W-1:0]         time_index;
    logic signed [FIELD_W-1:0] field_value;
    logic                      last_sample;
  } in_item_t;

  typedef struct packed {
    logic [LAG_W-1:0]         lag;
    logic signed [CORR_W-1:0] correlator;
    logic                     last_lag;
  } out_item_t;

  typedef struct packed {
    logic add;      // sample beat lands in the matching slice
    logic load;     // copy running sums into the shifted ring
    logic rot_sum;  // rotate the sum ring by one slice
    logic rot_shd;  // rotate the shifted ring by one slice
    logic clear;    // zero all running sums
  } cell_ctl_t;

endpackage

// ===== sv/zmtc_cell.sv =====
// one time slice: running sum plus a shifted copy, both on rotating rings
module zmtc_cell #(
  parameter int K    = 0,
  parameter int NT_W = 9
) (
  input  logic                         clk,
  input  logic                         rst,
  input  zmtc_pkg::cell_ctl_t          ctl,
  input  logic [zmtc_pkg::TIDX_W-1:0]  time_index,
  input  logic [zmtc_pkg::FIELD_W-1:0] field_value,
  input  logic [NT_W-1:0]              last_idx,
  input  logic [zmtc_pkg::SUM_W-1:0]   next_sum,
  input  logic [zmtc_pkg::SUM_W-1:0]   next_shd,
  input  logic [zmtc_pkg::SUM_W-1:0]   head_sum,
  input  logic [zmtc_pkg::SUM_W-1:0]   head_shd,
  output logic [zmtc_pkg::SUM_W-1:0]   sum_val,
  output logic [zmtc_pkg::SUM_W-1:0]   shd_val
);
  import zmtc_pkg::*;

  logic             is_tail;
  logic             hit;
  logic [SUM_W-1:0] field_ext;

  // the active tail wraps around to the head of the ring
  assign is_tail   = (32'(last_idx) == K);
  assign hit       = ctl.add && (32'(time_index) == K);
  assign field_ext = {{(SUM_W-FIELD_W){field_value[FIELD_W-1]}}, field_value};

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_val <= '0;
    end else if (ctl.clear) begin
      sum_val <= '0;
    end else if (hit) begin
      sum_val <= sum_val + field_ext;
    end else if (ctl.rot_sum) begin
      sum_val <= is_tail ? head_sum : next_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      shd_val <= sum_val;
    end else if (ctl.rot_shd) begin
      shd_val <= is_tail ? head_shd : next_shd;
    end
  end

endmodule

// ===== sv/zmtc_mac.sv =====
// clamp, multiply and saturating accumulate of the two ring heads
module zmtc_mac (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       issue,
  input  logic                       clear,
  input  logic [zmtc_pkg::SUM_W-1:0] a,
  input  logic [zmtc_pkg::SUM_W-1:0] b,
  output logic [zmtc_pkg::ACC_W-1:0] acc
);
  import zmtc_pkg::*;

  localparam logic [OPND_W-1:0] OPND_MAX = {1'b0, {(OPND_W-1){1'b1}}};
  localparam logic [OPND_W-1:0] OPND_MIN = {1'b1, {(OPND_W-1){1'b0}}};
  localparam logic [ACC_W-1:0]  ACC_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0]  ACC_MIN  = {1'b1, {(ACC_W-1){1'b0}}};

  function automatic logic [OPND_W-1:0] clamp_opnd(input logic [SUM_W-1:0] v);
    logic [SUM_W-OPND_W:0] top;
    top = v[SUM_W-1:OPND_W-1];
    if (top == '0 || top == '1) begin
      return v[OPND_W-1:0];
    end
    return v[SUM_W-1] ? OPND_MIN : OPND_MAX;
  endfunction

  logic [OPND_W-1:0] ca, cb;
  logic [ACC_W-1:0]  prod;
  logic              prod_valid;
  logic [ACC_W:0]    sum_ext;
  logic [ACC_W-1:0]  acc_next;

  assign ca = clamp_opnd(a);
  assign cb = clamp_opnd(b);

  // low product bits of sign-extended operands equal the signed product
  always_ff @(posedge clk) begin
    prod <= {{OPND_W{ca[OPND_W-1]}}, ca} * {{OPND_W{cb[OPND_W-1]}}, cb};
  end

  always_comb begin
    sum_ext = {acc[ACC_W-1], acc} + {prod[ACC_W-1], prod};
    if (sum_ext[ACC_W] != sum_ext[ACC_W-1]) begin
      acc_next = sum_ext[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_next = sum_ext[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      acc        <= '0;
    end else begin
      prod_valid <= issue;
      if (clear) begin
        acc <= '0;
      end else if (prod_valid) begin
        acc <= acc_next;
      end
    end
  end

endmodule

// ===== sv/zmtc_norm.sv =====
// scales the lag sum by the reciprocal norm, rounds and saturates to Q16.16
module zmtc_norm (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [zmtc_pkg::ACC_W-1:0]  acc,
  input  logic [zmtc_pkg::NORM_W-1:0] inv_norm,
  output logic                        done,
  output logic [zmtc_pkg::CORR_W-1:0] result
);
  import zmtc_pkg::*;

  localparam logic [ACC_W:0]    HALF     = (ACC_W+1)'(1) << (NORM_W - 1);
  localparam logic [CORR_W-1:0] CORR_MAX = {1'b0, {(CORR_W-1){1'b1}}};
  localparam logic [CORR_W-1:0] CORR_MIN = {1'b1, {(CORR_W-1){1'b0}}};

  logic [4:0]        st;
  logic              neg;
  logic [ACC_W-1:0]  mag;
  logic [ACC_W-1:0]  prod;
  logic [ACC_W-1:0]  lo;
  logic [ACC_W-1:0]  r;
  logic [NORM_W-1:0] mul_a;
  logic [ACC_W-1:0]  mul_p;
  logic [ACC_W:0]    lo_rnd;
  logic              over;

  // one multiplier: low half of the magnitude first, then the high half
  assign mul_a  = st[1] ? mag[ACC_W-1:NORM_W] : mag[NORM_W-1:0];
  assign mul_p  = {{(ACC_W-NORM_W){1'b0}}, mul_a} * {{(ACC_W-NORM_W){1'b0}}, inv_norm};
  assign lo_rnd = {1'b0, lo} + HALF;
  assign over   = (r[ACC_W-1:CORR_W-1] != '0);
  assign done   = st[4];

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else begin
      st <= {st[3:0], start};
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= acc[ACC_W-1];
      mag <= acc[ACC_W-1] ? (~acc + ACC_W'(1)) : acc;
    end
    if (st[0] || st[1]) begin
      prod <= mul_p;
    end
    if (st[1]) begin
      lo <= prod;
    end
    if (st[2]) begin
      r <= prod + {{(ACC_W-NORM_W-1){1'b0}}, lo_rnd[ACC_W:NORM_W]};
    end
    if (st[3]) begin
      if (!neg) begin
        result <= over ? CORR_MAX : r[CORR_W-1:0];
      end else begin
        result <= over ? CORR_MIN : (~r[CORR_W-1:0] + CORR_W'(1));
      end
    end
  end

endmodule

// ===== sv/zero_momentum_time_correlator.sv =====
// top level: sample accumulation ring, lag sequencer and output register
//
// Samples arrive on in_valid/in_ready, one beat per cycle while the block
// is accumulating: each beat adds its field value into the running sum of
// its time slice (slices at or above the active extent are skipped).
// A beat with last_sample set starts a measurement; in_ready stays low
// until it is finished. For each lag the sum ring and a shifted copy rotate
// through the active extent Nt, one product per cycle into the accumulator,
// then the scaling unit forms the Q16.16 value. The number of lags is Nt/4,
// capped at 64, and they all share the single multiply-accumulate unit.
// Results leave through a register on out_valid/out_ready; a stalled
// receiver holds the sequencer before the next lag. After the final lag
// all slice sums are zeroed in the clear state and the block takes samples
// again. Reset zeroes the sums, sets time_extent to 64 and inv_norm to 1.
// Registers are written through cfg_we/cfg_index/cfg_data; the user must
// write them only while idle, as the block itself does not enforce this.
module zero_momentum_time_correlator #(
  parameter int MAX_TIME = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  zmtc_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output zmtc_pkg::out_item_t           out_data,
  input  logic                          cfg_we,
  input  logic [zmtc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [zmtc_pkg::CFG_W-1:0]    cfg_data
);
  import zmtc_pkg::*;

  localparam int NT_W = $clog2(MAX_TIME + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_MAC   = 3'd2;
  localparam logic [2:0] S_ROT   = 3'd3;
  localparam logic [2:0] S_SCALE = 3'd4;
  localparam logic [2:0] S_NORM  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;
  localparam logic [2:0] S_CLEAR = 3'd7;

  logic [2:0]        state;
  logic [TE_W-1:0]   time_extent;
  logic [NORM_W-1:0] inv_norm;
  logic [NT_W-1:0]   j;
  logic [LAG_W-1:0]  lag_idx;

  logic [NT_W-1:0]   nt;
  logic [NT_W-1:0]   nt_m1;
  logic [31:0]       quarter;
  logic [LAGS_W-1:0] lags;
  logic              is_last_lag;
  logic              in_beat;
  logic              out_free;

  cell_ctl_t         cell_ctl;
  logic [SUM_W-1:0]  sum_q [MAX_TIME];
  logic [SUM_W-1:0]  shd_q [MAX_TIME];

  logic [ACC_W-1:0]  acc;
  logic              norm_done;
  logic [CORR_W-1:0] norm_result;

  // active extent clamped between MIN_TIME and the ring length
  always_comb begin
    if (32'(time_extent) > MAX_TIME) begin
      nt = NT_W'(MAX_TIME);
    end else if (32'(time_extent) < MIN_TIME) begin
      nt = NT_W'(MIN_TIME);
    end else begin
      nt = NT_W'(time_extent);
    end
  end

  assign nt_m1       = nt - NT_W'(1);
  assign quarter     = 32'(nt) >> 2;
  assign lags        = (quarter > 32'(LAG_LIMIT)) ? LAGS_W'(LAG_LIMIT) : quarter[LAGS_W-1:0];
  assign is_last_lag = ({1'b0, lag_idx} == lags - LAGS_W'(1));

  assign in_ready = (state == S_IDLE);
  assign in_beat  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cell_ctl.add     = in_beat && (32'(in_data.time_index) < 32'(nt));
    cell_ctl.load    = (state == S_LOAD);
    cell_ctl.rot_sum = (state == S_MAC);
    cell_ctl.rot_shd = (state == S_MAC) || (state == S_ROT);
    cell_ctl.clear   = (state == S_CLEAR);
  end

  for (genvar k = 0; k < MAX_TIME; k++) begin : g_cell
    zmtc_cell #(
      .K    (k),
      .NT_W (NT_W)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (cell_ctl),
      .time_index  (in_data.time_index),
      .field_value (in_data.field_value),
      .last_idx    (nt_m1),
      .next_sum    (sum_q[(k + 1) % MAX_TIME]),
      .next_shd    (shd_q[(k + 1) % MAX_TIME]),
      .head_sum    (sum_q[0]),
      .head_shd    (shd_q[0]),
      .sum_val     (sum_q[k]),
      .shd_val     (shd_q[k])
    );
  end

  zmtc_mac u_mac (
    .clk   (clk),
    .rst   (rst),
    .issue (state == S_MAC),
    .clear ((state == S_LOAD) || ((state == S_OUT) && out_free)),
    .a     (sum_q[0]),
    .b     (shd_q[0]),
    .acc   (acc)
  );

  zmtc_norm u_norm (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_SCALE),
    .acc      (acc),
    .inv_norm (inv_norm),
    .done     (norm_done),
    .result   (norm_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      j           <= '0;
      lag_idx     <= '0;
      out_valid   <= 1'b0;
      time_extent <= TE_W'(TE_RESET);
      inv_norm    <= NORM_W'(INV_RESET);
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TIME_EXTENT: time_extent <= cfg_data[TE_W-1:0];
          CFG_INV_NORM:    inv_norm    <= cfg_data[NORM_W-1:0];
          default: ;
        endcase
      end

      // the output state reloads the register itself when it is free
      if (out_valid && out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_beat && in_data.last_sample) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          j       <= '0;
          lag_idx <= '0;
          state   <= S_MAC;
        end
        S_MAC: begin
          if (j == nt_m1) begin
            j     <= '0;
            state <= S_ROT;
          end else begin
            j <= j + NT_W'(1);
          end
        end
        // shifted ring steps one slice ahead for the next lag
        S_ROT:   state <= S_SCALE;
        S_SCALE: state <= S_NORM;
        S_NORM: begin
          if (norm_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid           <= 1'b1;
            out_data.lag        <= lag_idx;
            out_data.correlator <= norm_result;
            out_data.last_lag   <= is_last_lag;
            if (is_last_lag) begin
              state <= S_CLEAR;
            end else begin
              lag_idx <= lag_idx + LAG_W'(1);
              state   <= S_MAC;
            end
          end
        end
        S_CLEAR: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_out_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled output beat dropped or changed");

  a_last_starts_run: assert property (@(posedge clk) disable iff (rst)
    (in_beat && in_data.last_sample) |=> (state == S_LOAD))
    else $error("last sample did not start a measurement");

  a_norm_done_waited: assert property (@(posedge clk) disable iff (rst)
    norm_done |-> (state == S_NORM))
    else $error("scaling result arrived outside its wait state");

  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_OUT))
    else $error("output beat raised outside the output state");

  a_sums_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |=> (sum_q[0] == '0))
    else $error("slice sums not cleared after measurement");

endmodule

// ===== dv/zmtc_checker.sv =====
// checker for the correlator: mirrors registers and slice sums, predicts and compares lag beats
module zmtc_checker
  import zmtc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  in_item_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   fails,
  output int                   pending
);

  localparam int     SLICES      = 256;
  localparam int     PRINT_CAP   = 40;
  localparam longint OPND_TOP    = 64'sd2147483647;
  localparam longint OPND_BOTTOM = -64'sd2147483648;
  localparam longint ACC_TOP     = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint ACC_BOTTOM  = -64'sh7FFF_FFFF_FFFF_FFFF - 64'sd1;

  logic signed [SUM_W-1:0] slice_total [SLICES];
  logic [TE_W-1:0]         extent_reg;
  logic [NORM_W-1:0]       norm_reg;
  out_item_t               lag_queue [$];

  task automatic report(input string what, input longint want, input longint got);
    fails++;
    if (fails <= PRINT_CAP) $display("mismatch on %s: expected %0d, got %0d", what, want, got);
  endtask

  function automatic longint clamp_operand(input logic signed [SUM_W-1:0] v);
    longint w;
    w = v;
    if (w > OPND_TOP) return OPND_TOP;
    if (w < OPND_BOTTOM) return OPND_BOTTOM;
    return w;
  endfunction

  function automatic longint add_saturating(input longint a, input longint b);
    logic signed [ACC_W:0] s;
    s = a;
    s = s + b;
    if (s > ACC_TOP) return ACC_TOP;
    if (s < ACC_BOTTOM) return ACC_BOTTOM;
    return s[ACC_W-1:0];
  endfunction

  // magnitude times Q0.32 reciprocal, round half away from zero, then sign and saturate
  function automatic logic [CORR_W-1:0] scale_to_q16(input longint acc,
                                                     input logic [NORM_W-1:0] inv);
    logic             neg;
    logic [ACC_W-1:0] mag;
    logic [96:0]      prod;
    logic [64:0]      q;
    neg = (acc < 0);
    mag = acc;
    if (neg) mag = ~mag + 1'b1;
    prod = mag * inv + 97'h8000_0000;
    q = prod[96:32];
    if (!neg) return (q > 65'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    if (q >= 65'h8000_0000) return 32'h8000_0000;
    return ~q[31:0] + 1'b1;
  endfunction

  task automatic absorb_sample(input in_item_t s);
    int        nt;
    int        lags;
    longint    acc;
    out_item_t r;
    nt = extent_reg;
    if (nt < MIN_TIME) nt = MIN_TIME;
    if (nt > SLICES) nt = SLICES;
    if (s.time_index < nt)
      slice_total[s.time_index] = slice_total[s.time_index]
          + {{(SUM_W-FIELD_W){s.field_value[FIELD_W-1]}}, s.field_value};
    if (!s.last_sample) return;
    lags = nt / 4;
    if (lags > LAG_LIMIT) lags = LAG_LIMIT;
    for (int i = 0; i < lags; i++) begin
      acc = 0;
      for (int j = 0; j < nt; j++)
        acc = add_saturating(acc, clamp_operand(slice_total[j])
                                  * clamp_operand(slice_total[(j + i) % nt]));
      r.lag        = LAG_W'(i);
      r.correlator = scale_to_q16(acc, norm_reg);
      r.last_lag   = (i == lags - 1);
      lag_queue.push_back(r);
    end
    foreach (slice_total[k]) slice_total[k] = '0;
  endtask

  task automatic check_lag(input out_item_t got);
    out_item_t want;
    if (lag_queue.size() == 0) begin
      report("unexpected lag beat", 0, got.lag);
      return;
    end
    want = lag_queue.pop_front();
    if (got.lag != want.lag) report("lag", want.lag, got.lag);
    if (got.correlator != want.correlator)
      report("correlator", want.correlator, got.correlator);
    if (got.last_lag != want.last_lag) report("last_lag", want.last_lag, got.last_lag);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (slice_total[k]) slice_total[k] = '0;
      extent_reg = TE_W'(TE_RESET);
      norm_reg   = NORM_W'(INV_RESET);
      lag_queue.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TIME_EXTENT: extent_reg = cfg_data[TE_W-1:0];
          CFG_INV_NORM:    norm_reg   = cfg_data[NORM_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) absorb_sample(in_data);
      if (out_valid && out_ready) check_lag(out_data);
    end
    pending = lag_queue.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// testbench top: clock, reset, sample and register stimulus, receiver pacing and verdict
module tb_top;
  import zmtc_pkg::*;

  localparam int          HOLD_CYCLES   = 600;
  localparam int          SETTLE_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT   = 2_000_000;
  localparam int          PHASES        = 10;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_TIME_EXTENT;
  logic [CFG_W-1:0]     cfg_data  = '0;

  int          fail_count;
  int          pending_count;
  int          idle_mode = 0;
  bit          hold_req  = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned cycle_count = 0;

  int unsigned extents [PHASES] = '{4, 16, 3, 8, 256, 7, 32, 12, 64, 20};

  zero_momentum_time_correlator dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  zmtc_checker u_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fails     (fail_count),
    .pending   (pending_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver pacing, with one long hold-off on request
  always begin
    @(negedge clk);
    if (hold_req && !hold_done) begin
      out_ready <= 1'b0;
      repeat (HOLD_CYCLES) @(negedge clk);
      hold_done = 1'b1;
    end else begin
      case (idle_mode)
        0:       out_ready <= ($urandom_range(99) >= 68);
        1:       out_ready <= ($urandom_range(99) >= 27);
        default: out_ready <= 1'b1;
      endcase
    end
  end

  function automatic bit sender_waits();
    case (idle_mode)
      0:       return $urandom_range(99) < 27;
      1:       return $urandom_range(99) < 68;
      default: return 1'b0;
    endcase
  endfunction

  function automatic in_item_t sample(input int t, input int v, input bit last);
    in_item_t s;
    s.time_index  = TIDX_W'(t);
    s.field_value = FIELD_W'(v);
    s.last_sample = last;
    return s;
  endfunction

  task automatic send_beat(input in_item_t s);
    @(negedge clk);
    while (sender_waits()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid, wait for every lag beat, then let the clear pass finish
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_measurement(input int nt, input int count);
    int t;
    int v;
    for (int k = 0; k < count; k++) begin
      // mostly in-range slices, some stray indices that must be skipped
      if ($urandom_range(99) < 80) t = $urandom_range(nt - 1, 0);
      else t = $urandom_range(255, 0);
      if ($urandom_range(1)) v = $urandom_range(65535, 0);
      else v = $signed($urandom_range(511, 0)) - 256;
      send_beat(sample(t, v, k == count - 1));
    end
  endtask

  initial begin
    int          nt;
    logic [31:0] inv;

    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // directed: extreme values, stray indices, clamped extents, extreme norms
    write_reg(CFG_TIME_EXTENT, 32'd8);
    write_reg(CFG_INV_NORM, 32'hFFFF_FFFF);
    send_beat(sample(0, 32767, 1'b0));
    send_beat(sample(7, -32768, 1'b0));
    send_beat(sample(3, 1, 1'b0));
    send_beat(sample(8, 100, 1'b0));
    send_beat(sample(255, -1, 1'b0));
    send_beat(sample(5, 0, 1'b0));
    send_beat(sample(1, -32768, 1'b1));
    settle();
    send_beat(sample(200, 555, 1'b1));
    settle();
    write_reg(CFG_TIME_EXTENT, 32'd0);
    write_reg(CFG_INV_NORM, 32'd0);
    send_beat(sample(2, 32767, 1'b0));
    send_beat(sample(3, -32768, 1'b1));
    settle();
    write_reg(CFG_TIME_EXTENT, 32'd511);
    write_reg(CFG_INV_NORM, 32'h0001_0000);
    send_beat(sample(255, 32767, 1'b0));
    send_beat(sample(128, -5, 1'b0));
    send_beat(sample(0, 77, 1'b1));
    settle();

    for (int p = 0; p < PHASES; p++) begin
      idle_mode = (p < 4) ? 0 : ((p < 7) ? 1 : 2);
      nt = extents[p];
      if (nt < MIN_TIME) nt = MIN_TIME;
      if (nt > 256) nt = 256;
      case (p % 3)
        0:       inv = $urandom;
        1:       inv = $urandom_range(1 << 20, 1);
        default: inv = $urandom_range(255, 0);
      endcase
      write_reg(CFG_TIME_EXTENT, extents[p]);
      write_reg(CFG_INV_NORM, inv);
      if (p == 1) hold_req = 1'b1;
      repeat (3) run_measurement(nt, $urandom_range(7, 1));
      settle();
    end

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
